// ----- hw/rtl/text_glyph_pixel_generator_defines.svh -----
// Assertion macros shared by the glyph pixel generator RTL.
`ifndef TEXT_GLYPH_PIXEL_GENERATOR_DEFINES_SVH
`define TEXT_GLYPH_PIXEL_GENERATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define TGPG_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tgpg assertion failed");

// Next-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define TGPG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tgpg assertion failed");

`endif

// ----- hw/rtl/tgpg_pkg.sv -----
// Package with field widths, codes, defaults and port structs of the glyph pixel generator.
package tgpg_pkg;

  localparam int unsigned GLYPH_WIDTH_DEF    = 6;
  localparam int unsigned GLYPH_HEIGHT_DEF   = 8;
  localparam int unsigned SCREEN_COLUMNS_DEF = 16;
  localparam int unsigned SCREEN_ROWS_DEF    = 8;
  localparam int unsigned GLYPH_COUNT_DEF    = 128;

  localparam int unsigned KIND_W     = 2;
  localparam int unsigned CODE_W     = 8;
  localparam int unsigned CCOL_W     = 5;
  localparam int unsigned CROW_W     = 4;
  localparam int unsigned FADDR_W    = 10;
  localparam int unsigned FDATA_W    = 8;
  localparam int unsigned PX_W       = 7;
  localparam int unsigned PY_W       = 6;
  localparam int unsigned COLOR_W    = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned BIT_IDX_W  = 3;

  localparam logic [CODE_W-1:0]  SKIP_MASK = 8'h80;
  localparam logic [COLOR_W-1:0] FG_RESET  = 16'd2016;
  localparam logic [COLOR_W-1:0] BG_RESET  = 16'd0;

  typedef enum logic [KIND_W-1:0] {
    KIND_FONT_WRITE,
    KIND_SET_CURSOR,
    KIND_DRAW,
    KIND_ADVANCE
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FOREGROUND,
    REG_BACKGROUND
  } reg_idx_e;

  typedef struct packed {
    logic               en;
    logic [FADDR_W-1:0] addr;
    logic [FDATA_W-1:0] data;
  } font_wr_t;

  typedef struct packed {
    logic               en;
    logic [FADDR_W-1:0] addr;
  } font_rd_t;

endpackage

// ----- hw/rtl/tgpg_if.sv -----
// Channel interfaces for command beats, pixel beats and register writes.
interface tgpg_in_if;
  import tgpg_pkg::*;
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [CODE_W-1:0]  char_code;
  logic [CCOL_W-1:0]  cursor_col;
  logic [CROW_W-1:0]  cursor_row;
  logic [FADDR_W-1:0] font_address;
  logic [FDATA_W-1:0] font_data;
  modport source (output valid, kind, char_code, cursor_col, cursor_row, font_address,
                  font_data, input ready);
  modport sink (input valid, kind, char_code, cursor_col, cursor_row, font_address,
                font_data, output ready);
endinterface

interface tgpg_out_if;
  import tgpg_pkg::*;
  logic               valid;
  logic               ready;
  logic [PX_W-1:0]    pixel_x;
  logic [PY_W-1:0]    pixel_y;
  logic [COLOR_W-1:0] pixel_color;
  logic               last_pixel;
  modport source (output valid, pixel_x, pixel_y, pixel_color, last_pixel, input ready);
  modport sink (input valid, pixel_x, pixel_y, pixel_color, last_pixel, output ready);
endinterface

interface tgpg_cfg_if;
  import tgpg_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [COLOR_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/tgpg_font_mem.sv -----
// Font memory with one write port and one registered read port.
module tgpg_font_mem #(
  parameter int unsigned DEPTH = tgpg_pkg::GLYPH_COUNT_DEF * tgpg_pkg::GLYPH_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  tgpg_pkg::font_wr_t            wr_i,
  input  tgpg_pkg::font_rd_t            rd_i,
  output logic [tgpg_pkg::FDATA_W-1:0]  rd_data_o
);
  import tgpg_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [FDATA_W-1:0] mem_q [DEPTH];
  logic [FDATA_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr[AW-1:0]] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      rd_data_q <= mem_q[rd_i.addr[AW-1:0]];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- hw/rtl/text_glyph_pixel_generator.sv -----
// Top level of the text-mode glyph pixel generator.
// A font write, cursor set or advance beat is taken in ST_IDLE; ready stays high, so one can follow.
// A drawn glyph loads its GLYPH_WIDTH font bytes, then emits GLYPH_WIDTH * GLYPH_HEIGHT pixels.
// The column fetch counter reads one font byte per cycle, then one pixel leaves per cycle while
// the output is not stalled. A skipped code only moves the cursor on, like an advance.
// Reset clears the cursor and the sequencer and restores the default colors; the font memory is
// not cleared.
module text_glyph_pixel_generator #(
  parameter int unsigned GLYPH_WIDTH    = tgpg_pkg::GLYPH_WIDTH_DEF,
  parameter int unsigned GLYPH_HEIGHT   = tgpg_pkg::GLYPH_HEIGHT_DEF,
  parameter int unsigned SCREEN_COLUMNS = tgpg_pkg::SCREEN_COLUMNS_DEF,
  parameter int unsigned SCREEN_ROWS    = tgpg_pkg::SCREEN_ROWS_DEF,
  parameter int unsigned GLYPH_COUNT    = tgpg_pkg::GLYPH_COUNT_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  tgpg_in_if.sink       in_i,
  tgpg_out_if.source    out_o,
  tgpg_cfg_if.sink      cfg_i
);
  import tgpg_pkg::*;
  `include "text_glyph_pixel_generator_defines.svh"

  localparam int unsigned STORE_DEPTH = GLYPH_COUNT * GLYPH_WIDTH;
  localparam int unsigned CNT_W       = $clog2(GLYPH_WIDTH + 1);
  localparam int unsigned COL_W       = (GLYPH_WIDTH > 1) ? $clog2(GLYPH_WIDTH) : 1;
  localparam int unsigned ROW_W       = (GLYPH_HEIGHT > 1) ? $clog2(GLYPH_HEIGHT) : 1;
  localparam int unsigned CUR_COL_W   = (SCREEN_COLUMNS > 1) ? $clog2(SCREEN_COLUMNS) : 1;
  localparam int unsigned CUR_ROW_W   = (SCREEN_ROWS > 1) ? $clog2(SCREEN_ROWS) : 1;

  localparam logic [CNT_W-1:0]     LD_END       = CNT_W'(GLYPH_WIDTH);
  localparam logic [COL_W-1:0]     COL_LAST     = COL_W'(GLYPH_WIDTH - 1);
  localparam logic [ROW_W-1:0]     ROW_LAST     = ROW_W'(GLYPH_HEIGHT - 1);
  localparam logic [CUR_COL_W-1:0] CUR_COL_LAST = CUR_COL_W'(SCREEN_COLUMNS - 1);
  localparam logic [CUR_ROW_W-1:0] CUR_ROW_LAST = CUR_ROW_W'(SCREEN_ROWS - 1);
  localparam logic [CCOL_W-1:0]    CCOL_MAX     = CCOL_W'(SCREEN_COLUMNS - 1);
  localparam logic [CROW_W-1:0]    CROW_MAX     = CROW_W'(SCREEN_ROWS - 1);
  localparam logic [FADDR_W:0]     DEPTH_EXT    = (FADDR_W + 1)'(STORE_DEPTH);
  localparam logic [CODE_W-1:0]    COUNT_CODE   = CODE_W'(GLYPH_COUNT);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_EMIT
  } state_e;

  state_e                 state_q;
  logic [CUR_COL_W-1:0]   cur_col_q, cur_col_d;
  logic [CUR_ROW_W-1:0]   cur_row_q, cur_row_d;
  logic [COLOR_W-1:0]     fg_q, bg_q;
  logic [FADDR_W-1:0]     base_q;
  logic                   zero_q;
  logic [CNT_W-1:0]       ld_cnt_q;
  logic                   rd_vld_q;
  logic [COL_W-1:0]       rd_idx_q;
  logic [FDATA_W-1:0]     cache_q [GLYPH_WIDTH];
  logic [COL_W-1:0]       col_q;
  logic [ROW_W-1:0]       row_q;
  logic [PX_W-1:0]        x_base_q, x_q;
  logic [PY_W-1:0]        y_q;
  logic                   out_valid_q;
  logic [PX_W-1:0]        px_q;
  logic [PY_W-1:0]        py_q;
  logic [COLOR_W-1:0]     color_q;
  logic                   last_q;

  kind_e                  kind;
  logic                   in_acc;
  logic                   draw_go;
  logic                   pix_load;
  logic                   pix_bit;
  logic [BIT_IDX_W-1:0]   bit_idx;
  logic [FDATA_W-1:0]     rd_data;
  font_wr_t               font_wr;
  font_rd_t               font_rd;

  assign kind        = kind_e'(in_i.kind);
  assign in_i.ready  = (state_q == ST_IDLE);
  assign in_acc      = in_i.valid && in_i.ready;
  assign draw_go     = in_acc && (kind == KIND_DRAW) && ((in_i.char_code & SKIP_MASK) == '0);
  assign cfg_i.ready = 1'b1;

  assign font_wr.en   = in_acc && (kind == KIND_FONT_WRITE) &&
                        ({1'b0, in_i.font_address} < DEPTH_EXT);
  assign font_wr.addr = in_i.font_address;
  assign font_wr.data = in_i.font_data;
  assign font_rd.en   = (state_q == ST_LOAD) && (ld_cnt_q < LD_END) && !zero_q;
  assign font_rd.addr = base_q + FADDR_W'(ld_cnt_q);

  tgpg_font_mem #(
    .DEPTH (STORE_DEPTH)
  ) u_font_mem (
    .clk_i     (clk_i),
    .wr_i      (font_wr),
    .rd_i      (font_rd),
    .rd_data_o (rd_data)
  );

  assign pix_load = (state_q == ST_EMIT) && (!out_valid_q || out_o.ready);
  assign bit_idx  = BIT_IDX_W'(row_q);
  assign pix_bit  = !zero_q && cache_q[col_q][bit_idx];

  always_comb begin
    cur_col_d = cur_col_q;
    cur_row_d = cur_row_q;
    if (in_acc) begin
      unique case (kind)
        KIND_SET_CURSOR: begin
          cur_col_d = (in_i.cursor_col > CCOL_MAX) ? CUR_COL_LAST :
                      CUR_COL_W'(in_i.cursor_col);
          cur_row_d = (in_i.cursor_row > CROW_MAX) ? CUR_ROW_LAST :
                      CUR_ROW_W'(in_i.cursor_row);
        end
        KIND_DRAW, KIND_ADVANCE: begin
          if (cur_col_q == CUR_COL_LAST) begin
            cur_col_d = '0;
            cur_row_d = (cur_row_q == CUR_ROW_LAST) ? '0 : cur_row_q + 1'b1;
          end else begin
            cur_col_d = cur_col_q + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_vld_q) begin
      cache_q[rd_idx_q] <= rd_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cur_col_q   <= '0;
      cur_row_q   <= '0;
      fg_q        <= FG_RESET;
      bg_q        <= BG_RESET;
      base_q      <= '0;
      zero_q      <= 1'b0;
      ld_cnt_q    <= '0;
      rd_vld_q    <= 1'b0;
      rd_idx_q    <= '0;
      col_q       <= '0;
      row_q       <= '0;
      x_base_q    <= '0;
      x_q         <= '0;
      y_q         <= '0;
      out_valid_q <= 1'b0;
      px_q        <= '0;
      py_q        <= '0;
      color_q     <= '0;
      last_q      <= 1'b0;
    end else begin
      cur_col_q <= cur_col_d;
      cur_row_q <= cur_row_d;
      rd_vld_q  <= font_rd.en;
      rd_idx_q  <= COL_W'(ld_cnt_q);

      if (cfg_i.valid && cfg_i.ready) begin
        unique case (cfg_i.index)
          REG_FOREGROUND: fg_q <= cfg_i.data;
          REG_BACKGROUND: bg_q <= cfg_i.data;
          default: begin
          end
        endcase
      end

      if (pix_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (draw_go) begin
            state_q  <= ST_LOAD;
            base_q   <= FADDR_W'(in_i.char_code * GLYPH_WIDTH);
            zero_q   <= (in_i.char_code >= COUNT_CODE);
            ld_cnt_q <= '0;
            col_q    <= '0;
            row_q    <= '0;
            x_base_q <= PX_W'(cur_col_q * GLYPH_WIDTH);
            x_q      <= PX_W'(cur_col_q * GLYPH_WIDTH);
            y_q      <= PY_W'(cur_row_q * GLYPH_HEIGHT);
          end
        end
        ST_LOAD: begin
          if (ld_cnt_q < LD_END) begin
            ld_cnt_q <= ld_cnt_q + 1'b1;
          end else if (!rd_vld_q) begin
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (pix_load) begin
            px_q    <= x_q;
            py_q    <= y_q;
            color_q <= pix_bit ? fg_q : bg_q;
            last_q  <= (col_q == COL_LAST) && (row_q == ROW_LAST);
            if (col_q == COL_LAST) begin
              col_q <= '0;
              x_q   <= x_base_q;
              if (row_q == ROW_LAST) begin
                state_q <= ST_IDLE;
              end else begin
                row_q <= row_q + 1'b1;
                y_q   <= y_q + 1'b1;
              end
            end else begin
              col_q <= col_q + 1'b1;
              x_q   <= x_q + 1'b1;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.pixel_x     = px_q;
  assign out_o.pixel_y     = py_q;
  assign out_o.pixel_color = color_q;
  assign out_o.last_pixel  = last_q;

  `TGPG_ASSERT_NEXT(a_draw_starts_load, draw_go, state_q == ST_LOAD)
  `TGPG_ASSERT_NOW(a_read_only_in_load, rd_vld_q, state_q == ST_LOAD)
  `TGPG_ASSERT_NEXT(a_last_pixel_ends_draw,
                    pix_load && (col_q == COL_LAST) && (row_q == ROW_LAST),
                    (state_q == ST_IDLE) && out_o.valid && out_o.last_pixel)

endmodule
